// File: rtl/pba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_pkg: shared types for the page bitmap allocator
// Command and result codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pba_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_RESERVE = 2'd3
  } pba_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_MEM  = 2'd1,
    ST_BAD_PG  = 2'd2,
    ST_IS_FREE = 2'd3
  } pba_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_READ,
    S_ALLOC_CHK,
    S_FREE_CHK,
    S_RANGE_WR,
    S_RESULT
  } pba_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic        load;
    logic        rd;
    logic        clr_wr;
    logic        alloc_wr;
    logic        free_wr;
    logic        range_wr;
    logic        ptr_inc;
    logic        res_load;
    pba_status_e res_status;
  } pba_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    pba_op_e op;
    logic    clr_done;
    logic    pool_empty;
    logic    free_oor;
    logic    range_empty;
    logic    word_full;
    logic    bit_free;
    logic    range_last;
  } pba_stat_t;

endpackage

// File: rtl/pba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_ctrl: sequencer of the page bitmap allocator
// Steps each request through the read, check and write cycles of the
// datapath and owns the request and result handshakes.
// ----------------------------------------------------------------------------
module pba_ctrl
  import pba_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  pba_stat_t stat_i,
  output pba_cmd_t  cmd_o
);

  pba_state_e  state_q, state_d;
  pba_status_e code_q, code_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      code_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '0;
    cmd_o.res_status = code_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          code_d     = ST_OK;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.op)
          OP_ALLOC: begin
            if (stat_i.pool_empty) begin
              code_d  = ST_NO_MEM;
              state_d = S_RESULT;
            end else begin
              cmd_o.rd = 1'b1;
              state_d  = S_ALLOC_CHK;
            end
          end
          OP_FREE: begin
            if (stat_i.free_oor) begin
              code_d  = ST_BAD_PG;
              state_d = S_RESULT;
            end else begin
              cmd_o.rd = 1'b1;
              state_d  = S_FREE_CHK;
            end
          end
          default: begin
            if (stat_i.range_empty) begin
              state_d = S_RESULT;
            end else begin
              cmd_o.rd = 1'b1;
              state_d  = S_RANGE_WR;
            end
          end
        endcase
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = (stat_i.op == OP_ALLOC) ? S_ALLOC_CHK : S_RANGE_WR;
      end
      S_ALLOC_CHK: begin
        if (stat_i.word_full) begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_READ;
        end else begin
          cmd_o.alloc_wr = 1'b1;
          state_d        = S_RESULT;
        end
      end
      S_FREE_CHK: begin
        if (stat_i.bit_free) begin
          code_d = ST_IS_FREE;
        end else begin
          cmd_o.free_wr = 1'b1;
        end
        state_d = S_RESULT;
      end
      S_RANGE_WR: begin
        cmd_o.range_wr = 1'b1;
        if (stat_i.range_last) begin
          state_d = S_RESULT;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_READ;
        end
      end
      S_RESULT: begin
        // The previous result must have left the output register first.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.res_load) out_valid_d = 1'b1;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_DECODE))
    else $error("accepted request not decoded");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clr_wr, cmd_o.alloc_wr, cmd_o.free_wr, cmd_o.range_wr}))
    else $error("more than one bitmap write at once");

endmodule

// File: rtl/pba_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_datapath: bitmap memory and counters of the page bitmap allocator
// Holds the used-page bitmap as 32-bit words, the free count, the highest
// released end, the search hint and the result register.
// ----------------------------------------------------------------------------
module pba_datapath
  import pba_pkg::*;
#(
  parameter int unsigned NUM_PAGES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pba_cmd_t    cmd_i,
  output pba_stat_t   stat_o,
  input  logic [1:0]  command_i,
  input  logic [11:0] first_page_i,
  input  logic [12:0] range_end_i,
  output logic [1:0]  status_o,
  output logic [11:0] page_index_o,
  output logic [12:0] free_pages_o,
  output logic [12:0] highest_end_o
);

  localparam int unsigned Words = (NUM_PAGES + 31) / 32;
  localparam int unsigned AW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned PW = ($clog2(NUM_PAGES + 1) > 13) ? $clog2(NUM_PAGES + 1) : 13;

  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [1:0] s1 [16];
    logic [2:0] s2 [8];
    logic [3:0] s3 [4];
    logic [4:0] s4 [2];
    for (int i = 0; i < 16; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 8; i++)  s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    for (int i = 0; i < 4; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    for (int i = 0; i < 2; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    return {1'b0, s4[0]} + {1'b0, s4[1]};
  endfunction

  logic [31:0] mem [Words];
  logic [31:0] rdata_q;

  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] lo_q, lo_d;
  logic [PW-1:0] free_cnt_q, free_cnt_d;
  logic [12:0]   hi_end_q, hi_end_d;

  pba_op_e       op_q;
  logic [11:0]   first_q;
  logic [PW-1:0] endc_q;
  logic [11:0]   grant_q;

  logic [1:0]    status_q;
  logic [11:0]   page_q;
  logic [12:0]   free_out_q;
  logic [12:0]   hi_out_q;

  logic [PW-1:0] in_first_ext, in_end_ext, in_endc;
  logic [PW-1:0] first_ext, last_pg;
  logic [AW-1:0] in_first_w, first_w, last_w;
  logic [31:0]   inv, low_zero, free_bit, lo_mask, hi_mask, rmask;
  logic [31:0]   range_new, wdata;
  logic [4:0]    zero_idx;
  logic [5:0]    flips;
  logic          releasing, we;

  assign in_first_ext = PW'(first_page_i);
  assign in_end_ext   = PW'(range_end_i);
  assign in_endc      = (in_end_ext > PW'(NUM_PAGES)) ? PW'(NUM_PAGES) : in_end_ext;
  assign in_first_w   = AW'(in_first_ext[PW-1:5]);

  assign first_ext = PW'(first_q);
  assign first_w   = AW'(first_ext[PW-1:5]);
  assign last_pg   = endc_q - PW'(1);
  assign last_w    = AW'(last_pg[PW-1:5]);

  // Lowest clear bit of the word read for an allocation.
  assign inv      = ~rdata_q;
  assign low_zero = inv & (~inv + 32'd1);
  always_comb begin
    zero_idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (low_zero[i]) zero_idx = zero_idx | 5'(i);
    end
  end

  assign free_bit = 32'd1 << first_q[4:0];

  // Bits of the current word that fall inside [first, end).
  assign lo_mask = (ptr_q == first_w) ? ('1 << first_q[4:0]) : '1;
  assign hi_mask = (ptr_q == last_w) ? ('1 >> (5'd31 - last_pg[4:0])) : '1;
  assign rmask   = lo_mask & hi_mask;

  assign releasing = (op_q == OP_RELEASE);
  assign range_new = releasing ? (rdata_q & ~rmask) : (rdata_q | rmask);
  assign flips     = releasing ? popcount32(rdata_q & rmask) : popcount32(~rdata_q & rmask);

  always_comb begin
    wdata = '1;
    if (cmd_i.alloc_wr) wdata = rdata_q | low_zero;
    if (cmd_i.free_wr)  wdata = rdata_q & ~free_bit;
    if (cmd_i.range_wr) wdata = range_new;
  end
  assign we = cmd_i.clr_wr | cmd_i.alloc_wr | cmd_i.free_wr | cmd_i.range_wr;

  always_ff @(posedge clk_i) begin
    if (we) mem[ptr_q] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rdata_q <= mem[ptr_q];
  end

  always_comb begin
    ptr_d      = ptr_q;
    lo_d       = lo_q;
    free_cnt_d = free_cnt_q;
    hi_end_d   = hi_end_q;
    if (cmd_i.load) begin
      ptr_d = (pba_op_e'(command_i) == OP_ALLOC) ? lo_q : in_first_w;
      if ((pba_op_e'(command_i) == OP_RELEASE) && (range_end_i > hi_end_q)) begin
        hi_end_d = range_end_i;
      end
    end
    if (cmd_i.ptr_inc) ptr_d = ptr_q + AW'(1);
    if (cmd_i.alloc_wr) begin
      free_cnt_d = free_cnt_q - PW'(1);
      lo_d       = ptr_q;
    end
    if (cmd_i.free_wr) begin
      free_cnt_d = free_cnt_q + PW'(1);
      if (ptr_q < lo_q) lo_d = ptr_q;
    end
    if (cmd_i.range_wr) begin
      if (releasing) begin
        free_cnt_d = free_cnt_q + PW'(flips);
        if (ptr_q < lo_q) lo_d = ptr_q;
      end else begin
        free_cnt_d = free_cnt_q - PW'(flips);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      lo_q       <= '0;
      free_cnt_q <= '0;
      hi_end_q   <= '0;
    end else begin
      ptr_q      <= ptr_d;
      lo_q       <= lo_d;
      free_cnt_q <= free_cnt_d;
      hi_end_q   <= hi_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= pba_op_e'(command_i);
      first_q <= first_page_i;
      endc_q  <= in_endc;
      grant_q <= '0;
    end
    if (cmd_i.alloc_wr) grant_q <= 12'({ptr_q, zero_idx});
    if (cmd_i.res_load) begin
      status_q   <= cmd_i.res_status;
      page_q     <= grant_q;
      free_out_q <= free_cnt_q[12:0];
      hi_out_q   <= hi_end_q;
    end
  end

  assign stat_o.op          = op_q;
  assign stat_o.clr_done    = (ptr_q == AW'(Words - 1));
  assign stat_o.pool_empty  = (free_cnt_q == '0);
  assign stat_o.free_oor    = (first_ext >= PW'(NUM_PAGES));
  assign stat_o.range_empty = (first_ext >= endc_q);
  assign stat_o.word_full   = (rdata_q == '1);
  assign stat_o.bit_free    = ~rdata_q[first_q[4:0]];
  assign stat_o.range_last  = (ptr_q == last_w);

  assign status_o      = status_q;
  assign page_index_o  = page_q;
  assign free_pages_o  = free_out_q;
  assign highest_end_o = hi_out_q;

  a_alloc_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_wr |-> (rdata_q != '1) && (free_cnt_q != '0))
    else $error("allocation from a full word or an empty pool");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= PW'(NUM_PAGES))
    else $error("free count above pool size");

endmodule

// File: rtl/page_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_bitmap_allocator: first-fit page frame allocator over a bitmap
// Top level joining the sequencer and the bitmap datapath.
// ----------------------------------------------------------------------------
// Usage: a request (command, first_page, range_end) is taken when in_valid_i
// is high and in_stall_o is low; each request gives exactly one result
// (status, page_index, free_pages, highest_end), offered on out_valid_o and
// taken when out_stall_i is low. Requests are handled one at a time. A free
// reads its word in S_DECODE and writes it in S_FREE_CHK; an allocate reads
// the word at the search hint and re-reads through S_READ for each full word
// skipped; a range reads and writes each bitmap word it covers in turn; an
// allocate with no free page, a free out of range and an empty range go
// straight to S_RESULT. The steps come from the single port of the 32-bit
// bitmap memory: each word is read into a register, then checked or written.
// After reset the block fills the bitmap with ones, one word per cycle
// (NUM_PAGES/32 words, rounded up), holding in_stall_o high.
// A finished result waits in the output register while the next request is
// taken; if the receiver stalls, the block holds before loading the
// following result and stops taking requests until the register frees.
// ----------------------------------------------------------------------------
module page_bitmap_allocator
  import pba_pkg::*;
#(
  parameter int unsigned NUM_PAGES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [11:0] first_page_i,
  input  logic [12:0] range_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [11:0] page_index_o,
  output logic [12:0] free_pages_o,
  output logic [12:0] highest_end_o
);

  pba_cmd_t  cmd;
  pba_stat_t stat;

  pba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pba_datapath #(
    .NUM_PAGES (NUM_PAGES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .command_i     (command_i),
    .first_page_i  (first_page_i),
    .range_end_i   (range_end_i),
    .status_o      (status_o),
    .page_index_o  (page_index_o),
    .free_pages_o  (free_pages_o),
    .highest_end_o (highest_end_o)
  );

endmodule
